// File: design/hbrp_pkg.sv
// Package for the HTTP byte-range parser: widths, parse phases, character codes, helpers.
package hbrp_pkg;

    localparam int OFFSET_BITS_DEF = 48;
    localparam int PREFIX_LEN      = 6;

    // parse phase codes
    localparam logic [1:0] PH_LEAD   = 2'd0;
    localparam logic [1:0] PH_PREFIX = 2'd1;
    localparam logic [1:0] PH_SPEC   = 2'd2;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_Y     = 8'h79;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_S     = 8'h73;

    // Flags captured with the final character of one header.
    typedef struct packed {
        logic base_ok;      // not failed, prefix done, dash seen, size nonzero
        logic first_seen;
        logic last_seen;
    } t_snap_flags;

    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = CH_B;
            3'd1:    ch = CH_Y;
            3'd2:    ch = CH_T;
            3'd3:    ch = CH_E;
            3'd4:    ch = CH_S;
            3'd5:    ch = CH_EQUAL;
            default: ch = CH_COMMA;   // never matched: guarded by the count check
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c inside {[8'h41:8'h5A]}) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

endpackage

// File: design/hbrp_in_if.sv
// Input channel: one header character per beat, with last mark and resource size.
interface hbrp_in_if #(
    parameter int OFFSET_BITS = hbrp_pkg::OFFSET_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [7:0]             value_byte;
    logic                   last_byte;
    logic [OFFSET_BITS-1:0] resource_size;

    modport source (output valid, output value_byte, output last_byte,
                    output resource_size, input ready);
    modport sink   (input valid, input value_byte, input last_byte,
                    input resource_size, output ready);
endinterface

// File: design/hbrp_out_if.sv
// Output channel: one range result per beat.
interface hbrp_out_if #(
    parameter int OFFSET_BITS = hbrp_pkg::OFFSET_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic                   range_status;
    logic [OFFSET_BITS-1:0] range_first;
    logic [OFFSET_BITS-1:0] range_last;

    modport source (output valid, output range_status, output range_first,
                    output range_last, input ready);
    modport sink   (input valid, input range_status, input range_first,
                    input range_last, output ready);
endinterface

// File: design/hbrp_scan.sv
// Character scanner: parse state per header and the snapshot taken at the last character.
module hbrp_scan #(
    parameter int OFFSET_BITS = hbrp_pkg::OFFSET_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_beat,        // input beat accepted
    input  logic [7:0]             i_value_byte,
    input  logic                   i_last_byte,
    input  logic [OFFSET_BITS-1:0] i_resource_size,
    input  logic                   i_snap_take,   // snapshot moves on this cycle
    output logic                   o_snap_valid,
    output hbrp_pkg::t_snap_flags  o_snap_flags,
    output logic [OFFSET_BITS-1:0] o_snap_first,
    output logic [OFFSET_BITS-1:0] o_snap_last,
    output logic [OFFSET_BITS-1:0] o_snap_size
);
    localparam int AW = OFFSET_BITS + 4;

    logic [1:0]             r_phase, n_phase;
    logic [2:0]             r_prefix_count, n_prefix_count;
    logic [OFFSET_BITS-1:0] r_first, n_first;
    logic [OFFSET_BITS-1:0] r_last, n_last;
    logic                   r_first_seen, n_first_seen;
    logic                   r_last_seen, n_last_seen;
    logic                   r_dash_seen, n_dash_seen;
    logic                   r_gap_seen, n_gap_seen;
    logic                   r_failed, n_failed;

    logic                   r_snap_valid;
    hbrp_pkg::t_snap_flags  r_snap_flags;
    logic [OFFSET_BITS-1:0] r_snap_first, r_snap_last, r_snap_size;

    logic [OFFSET_BITS-1:0] acc_in;
    logic [AW-1:0]          acc_prod;
    logic                   acc_ovf;
    logic [1:0]             eff_phase;
    logic                   is_digit;

    // accumulator feeds the number that the next digit belongs to
    assign acc_in   = r_dash_seen ? r_last : r_first;
    assign acc_prod = ({4'b0, acc_in} << 3) + ({4'b0, acc_in} << 1)
                    + {(OFFSET_BITS)'(0), i_value_byte[3:0]};
    assign acc_ovf  = |acc_prod[AW-1:OFFSET_BITS];
    assign is_digit = i_value_byte inside {[8'h30:8'h39]};

    always_comb begin
        n_phase        = r_phase;
        n_prefix_count = r_prefix_count;
        n_first        = r_first;
        n_last         = r_last;
        n_first_seen   = r_first_seen;
        n_last_seen    = r_last_seen;
        n_dash_seen    = r_dash_seen;
        n_gap_seen     = r_gap_seen;
        n_failed       = r_failed;
        eff_phase      = r_phase;

        if (!r_failed) begin
            if (r_phase == hbrp_pkg::PH_LEAD && !hbrp_pkg::is_ws(i_value_byte)) begin
                eff_phase = hbrp_pkg::PH_PREFIX;
                n_phase   = hbrp_pkg::PH_PREFIX;
            end
            case (eff_phase)
                hbrp_pkg::PH_LEAD: begin
                end
                hbrp_pkg::PH_PREFIX: begin
                    if (r_prefix_count >= 3'(hbrp_pkg::PREFIX_LEN) ||
                        hbrp_pkg::to_lower(i_value_byte) !=
                        hbrp_pkg::prefix_char(r_prefix_count)) begin
                        n_failed = 1'b1;
                    end else begin
                        n_prefix_count = r_prefix_count + 3'd1;
                        if (r_prefix_count == 3'(hbrp_pkg::PREFIX_LEN - 1)) begin
                            n_phase = hbrp_pkg::PH_SPEC;
                        end
                    end
                end
                hbrp_pkg::PH_SPEC: begin
                    if (hbrp_pkg::is_ws(i_value_byte)) begin
                        if (r_first_seen || r_dash_seen) begin
                            n_gap_seen = 1'b1;
                        end
                    end else if (r_gap_seen) begin
                        n_failed = 1'b1;
                    end else if (is_digit) begin
                        if (acc_ovf) begin
                            n_failed = 1'b1;
                        end else if (r_dash_seen) begin
                            n_last = acc_prod[OFFSET_BITS-1:0];
                        end else begin
                            n_first = acc_prod[OFFSET_BITS-1:0];
                        end
                        if (r_dash_seen) begin
                            n_last_seen = 1'b1;
                        end else begin
                            n_first_seen = 1'b1;
                        end
                    end else if (i_value_byte == hbrp_pkg::CH_DASH && !r_dash_seen) begin
                        n_dash_seen = 1'b1;
                    end else begin
                        n_failed = 1'b1;
                    end
                end
                default: begin
                    n_failed = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= hbrp_pkg::PH_LEAD;
            r_prefix_count <= 3'd0;
            r_first        <= '0;
            r_last         <= '0;
            r_first_seen   <= 1'b0;
            r_last_seen    <= 1'b0;
            r_dash_seen    <= 1'b0;
            r_gap_seen     <= 1'b0;
            r_failed       <= 1'b0;
            r_snap_valid   <= 1'b0;
        end else begin
            if (i_beat && i_last_byte) begin
                // header done: back to the idle parse state
                r_phase        <= hbrp_pkg::PH_LEAD;
                r_prefix_count <= 3'd0;
                r_first        <= '0;
                r_last         <= '0;
                r_first_seen   <= 1'b0;
                r_last_seen    <= 1'b0;
                r_dash_seen    <= 1'b0;
                r_gap_seen     <= 1'b0;
                r_failed       <= 1'b0;
            end else if (i_beat) begin
                r_phase        <= n_phase;
                r_prefix_count <= n_prefix_count;
                r_first        <= n_first;
                r_last         <= n_last;
                r_first_seen   <= n_first_seen;
                r_last_seen    <= n_last_seen;
                r_dash_seen    <= n_dash_seen;
                r_gap_seen     <= n_gap_seen;
                r_failed       <= n_failed;
            end
            if (i_beat && i_last_byte) begin
                r_snap_valid <= 1'b1;
            end else if (i_snap_take) begin
                r_snap_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_beat && i_last_byte) begin
            r_snap_flags.base_ok    <= !n_failed && n_phase == hbrp_pkg::PH_SPEC &&
                                       n_dash_seen && (i_resource_size != '0);
            r_snap_flags.first_seen <= n_first_seen;
            r_snap_flags.last_seen  <= n_last_seen;
            r_snap_first            <= n_first;
            r_snap_last             <= n_last;
            r_snap_size             <= i_resource_size;
        end
    end

    assign o_snap_valid = r_snap_valid;
    assign o_snap_flags = r_snap_flags;
    assign o_snap_first = r_snap_first;
    assign o_snap_last  = r_snap_last;
    assign o_snap_size  = r_snap_size;

endmodule

// File: design/http_byte_range_parser_unit.sv
// Top level of the HTTP single byte-range parser: scanner, range check and result register.
//
//   channel  dir  payload                                         beat
//   i_in     in   value_byte[8] last_byte[1] resource_size[48]    valid & ready
//   o_out    out  range_status[1] range_first[48] range_last[48]  valid & ready
//
// One character per cycle while i_in.ready is high. A header's result moves from the
// scanner snapshot, loaded as its last character is taken, to the result register
// once that is free. Reset (synchronous, active low) returns the parser to the
// leading whitespace phase and empties both stages. i_in.ready drops only while both
// the snapshot and the result register hold results and o_out is stalled.
module http_byte_range_parser_unit #(
    parameter int OFFSET_BITS = hbrp_pkg::OFFSET_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hbrp_in_if.sink    i_in,
    hbrp_out_if.source o_out
);
    logic                   snap_valid, snap_take, in_beat;
    hbrp_pkg::t_snap_flags  snap_flags;
    logic [OFFSET_BITS-1:0] snap_first, snap_last, snap_size;

    logic                   res_ok;
    logic [OFFSET_BITS-1:0] res_first, res_last, size_m1, suffix_take;

    logic                   r_out_valid;
    logic                   r_out_status;
    logic [OFFSET_BITS-1:0] r_out_first, r_out_last;

    assign snap_take  = snap_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !snap_valid || snap_take;
    assign in_beat    = i_in.valid && i_in.ready;

    hbrp_scan #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_scan (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_beat          (in_beat),
        .i_value_byte    (i_in.value_byte),
        .i_last_byte     (i_in.last_byte),
        .i_resource_size (i_in.resource_size),
        .i_snap_take     (snap_take),
        .o_snap_valid    (snap_valid),
        .o_snap_flags    (snap_flags),
        .o_snap_first    (snap_first),
        .o_snap_last     (snap_last),
        .o_snap_size     (snap_size)
    );

    assign size_m1     = snap_size - OFFSET_BITS'(1);
    assign suffix_take = (snap_last < snap_size) ? snap_last : snap_size;

    always_comb begin
        res_ok    = snap_flags.base_ok;
        res_first = '0;
        res_last  = '0;
        if (!snap_flags.first_seen) begin
            // suffix form: last N bytes
            if (!snap_flags.last_seen || snap_last == '0) begin
                res_ok = 1'b0;
            end else begin
                res_first = snap_size - suffix_take;
                res_last  = size_m1;
            end
        end else if (snap_first >= snap_size) begin
            res_ok = 1'b0;
        end else begin
            res_first = snap_first;
            res_last  = size_m1;
            if (snap_flags.last_seen) begin
                if (snap_last < snap_first) begin
                    res_ok = 1'b0;
                end else if (snap_last < size_m1) begin
                    res_last = snap_last;
                end
            end
        end
        if (!res_ok) begin
            res_first = '0;
            res_last  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (snap_take) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (snap_take) begin
            r_out_status <= !res_ok;
            r_out_first  <= res_first;
            r_out_last   <= res_last;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.range_status = r_out_status;
    assign o_out.range_first  = r_out_first;
    assign o_out.range_last   = r_out_last;

endmodule

// File: dv/tb.sv
// Self-checking testbench for the HTTP single byte-range parser.
`timescale 1ns / 100ps

module tb;

    localparam int          OB         = hbrp_pkg::OFFSET_BITS_DEF;
    localparam logic [63:0] OFFSET_MAX = (64'd1 << OB) - 64'd1;
    localparam logic [47:0] PREFIX_TEXT = "bytes=";
    localparam logic [7:0]  CH_ZERO    = 8'h30;
    localparam logic [7:0]  CH_NINE    = 8'h39;
    localparam logic [7:0]  CH_UP_A    = 8'h41;
    localparam logic [7:0]  CH_UP_Z    = 8'h5A;
    localparam int          ITEM_BEATS = 1000;
    localparam int          TAIL_BEATS = 120;
    localparam int          HOLD_LEN   = 120;
    localparam int          CYCLE_CAP  = 400000;

    typedef struct packed {
        logic [7:0]    ch;
        logic          lst;
        logic [OB-1:0] size;
    } t_hdr_beat;

    typedef struct packed {
        logic          status;
        logic [OB-1:0] first;
        logic [OB-1:0] last;
    } t_range;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hbrp_in_if  #(.OFFSET_BITS(OB)) in_if ();
    hbrp_out_if #(.OFFSET_BITS(OB)) out_if ();

    http_byte_range_parser_unit #(.OFFSET_BITS(OB)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_hdr_beat   pend_q[$];
    logic [7:0]  hdr_q[$];
    t_range      range_q[$];
    t_range      want;
    int          errors;
    int          beats_in;
    int          n_headers;
    int          n_ok;
    int          n_bad;
    int          hold_at;
    int          hold_left;
    bit          hold_done;
    int          src_gap;
    int          snk_gap;
    int          cycles;

    // predictor copy of the scanner state
    logic [1:0]  sc_phase;
    int          sc_pcount;
    logic [63:0] sc_first_acc;
    logic [63:0] sc_last_acc;
    bit          sc_first_seen;
    bit          sc_last_seen;
    bit          sc_dash;
    bit          sc_gap;
    bit          sc_failed;

    function automatic bit is_blank(input logic [7:0] c);
        return (c == hbrp_pkg::CH_SPACE) || (c == hbrp_pkg::CH_TAB);
    endfunction

    function automatic void clear_scan();
        sc_phase      = hbrp_pkg::PH_LEAD;
        sc_pcount     = 0;
        sc_first_acc  = '0;
        sc_last_acc   = '0;
        sc_first_seen = 1'b0;
        sc_last_seen  = 1'b0;
        sc_dash       = 1'b0;
        sc_gap        = 1'b0;
        sc_failed     = 1'b0;
    endfunction

    // decimal accumulate; stops and flags once the offset width is exceeded
    function automatic logic [63:0] grow(input logic [63:0] acc, input logic [63:0] d);
        if (acc > (OFFSET_MAX - d) / 64'd10) begin
            sc_failed = 1'b1;
            return acc;
        end
        return acc * 64'd10 + d;
    endfunction

    function automatic void scan_char(input logic [7:0] c);
        logic [7:0] lc;
        if (sc_failed) return;
        if (sc_phase == hbrp_pkg::PH_LEAD) begin
            if (is_blank(c)) return;
            sc_phase = hbrp_pkg::PH_PREFIX;
        end
        if (sc_phase == hbrp_pkg::PH_PREFIX) begin
            lc = (c >= CH_UP_A && c <= CH_UP_Z) ? c + 8'd32 : c;
            if (sc_pcount >= hbrp_pkg::PREFIX_LEN ||
                lc != PREFIX_TEXT[8*(hbrp_pkg::PREFIX_LEN-1-sc_pcount) +: 8]) begin
                sc_failed = 1'b1;
                return;
            end
            sc_pcount++;
            if (sc_pcount == hbrp_pkg::PREFIX_LEN) sc_phase = hbrp_pkg::PH_SPEC;
            return;
        end
        if (sc_phase != hbrp_pkg::PH_SPEC) begin
            sc_failed = 1'b1;
            return;
        end
        if (is_blank(c)) begin
            if (sc_first_seen || sc_dash) sc_gap = 1'b1;
            return;
        end
        if (sc_gap) begin
            sc_failed = 1'b1;
            return;
        end
        if (c >= CH_ZERO && c <= CH_NINE) begin
            if (sc_dash) begin
                sc_last_acc  = grow(sc_last_acc, {56'd0, c - CH_ZERO});
                sc_last_seen = 1'b1;
            end else begin
                sc_first_acc  = grow(sc_first_acc, {56'd0, c - CH_ZERO});
                sc_first_seen = 1'b1;
            end
            return;
        end
        if (c == hbrp_pkg::CH_DASH && !sc_dash) begin
            sc_dash = 1'b1;
            return;
        end
        sc_failed = 1'b1;
    endfunction

    function automatic t_range close_header(input logic [OB-1:0] size);
        t_range      r;
        logic        ok;
        logic [63:0] sz;
        logic [63:0] take;
        logic [63:0] lastoff;
        sz      = 64'(size);
        lastoff = sz - 64'd1;
        r       = '0;
        ok      = !sc_failed && sc_phase == hbrp_pkg::PH_SPEC && sc_dash && sz != 0;
        if (ok) begin
            if (!sc_first_seen) begin
                if (!sc_last_seen || sc_last_acc == 0) begin
                    ok = 1'b0;
                end else begin
                    take    = (sc_last_acc < sz) ? sc_last_acc : sz;
                    r.first = OB'(sz - take);
                    r.last  = OB'(lastoff);
                end
            end else if (sc_first_acc >= sz) begin
                ok = 1'b0;
            end else begin
                r.first = OB'(sc_first_acc);
                r.last  = OB'(lastoff);
                if (sc_last_seen) begin
                    if (sc_last_acc < sc_first_acc) ok = 1'b0;
                    else if (sc_last_acc < lastoff) r.last = OB'(sc_last_acc);
                end
            end
        end
        if (!ok) begin
            r        = '0;
            r.status = 1'b1;
        end
        clear_scan();
        return r;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] w);
        errors++;
        $display("tb: mismatch %s got %0h want %0h (cycle %0d)", what, got, w, cycles);
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] w);
        if (got !== w) report(what, got, w);
    endtask

    // ---- stimulus construction ----
    task automatic add_byte(input logic [7:0] c, input logic [OB-1:0] size, input bit mark);
        t_hdr_beat b;
        b.ch   = c;
        b.lst  = mark;
        b.size = size;
        pend_q.insert(pend_q.size(), b);
    endtask

    task automatic push_text(input string s, input logic [OB-1:0] size, input bit mark);
        for (int i = 0; i < s.len(); i++) begin
            add_byte(s[i], size, mark && (i == s.len() - 1));
        end
    endtask

    function automatic logic [7:0] blank();
        return $urandom_range(0, 1) ? hbrp_pkg::CH_TAB : hbrp_pkg::CH_SPACE;
    endfunction

    function automatic logic [63:0] pick_size();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return 64'd0;
        if (r == 1) return OFFSET_MAX;
        if (r <= 5) return 64'($urandom_range(1, 3000));
        return {$urandom, $urandom} & OFFSET_MAX;
    endfunction

    function automatic logic [63:0] pick_offset(input logic [63:0] sz);
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       v = 64'd0;
            1:       v = sz;
            2:       v = (sz == 0) ? 64'd0 : sz - 64'd1;
            3:       ;                          // wide: usually overflows
            4:       v = v & OFFSET_MAX;
            default: v = (sz == 0) ? (v & 64'h3FF) : v % sz;
        endcase
        return v;
    endfunction

    task automatic push_number(input logic [63:0] v);
        string s;
        if ($urandom_range(0, 7) == 0) hdr_q.insert(hdr_q.size(), CH_ZERO);
        s = $sformatf("%0d", v);
        for (int i = 0; i < s.len(); i++) hdr_q.insert(hdr_q.size(), s[i]);
    endtask

    task automatic gen_header();
        logic [63:0] sz;
        logic [63:0] fv;
        logic [7:0]  c;
        int unsigned kind;
        int unsigned form;
        int unsigned k;
        t_hdr_beat   b;
        hdr_q.delete();
        kind = $urandom_range(0, 9);
        sz   = pick_size();
        if (kind == 0) begin
            k = $urandom_range(1, 8);
            repeat (k) hdr_q.insert(hdr_q.size(), 8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(0, 2)) hdr_q.insert(hdr_q.size(), blank());
            for (int i = 0; i < hbrp_pkg::PREFIX_LEN; i++) begin
                c = PREFIX_TEXT[8*(hbrp_pkg::PREFIX_LEN-1-i) +: 8];
                if (c != hbrp_pkg::CH_EQUAL && $urandom_range(0, 1)) c = c - 8'd32;
                hdr_q.insert(hdr_q.size(), c);
            end
            repeat ($urandom_range(0, 1)) hdr_q.insert(hdr_q.size(), blank());
            form = $urandom_range(0, 3);
            fv   = pick_offset(sz);
            if (form != 0) push_number(fv);
            hdr_q.insert(hdr_q.size(), hbrp_pkg::CH_DASH);
            if (form == 0) begin
                push_number(pick_offset(sz));
            end else if (form >= 2) begin
                case ($urandom_range(0, 3))
                    0:       push_number(pick_offset(sz));
                    1:       push_number((fv == 0) ? fv : fv - 64'd1);
                    default: push_number(fv + 64'($urandom_range(0, 300)));
                endcase
            end
            repeat ($urandom_range(0, 2)) hdr_q.insert(hdr_q.size(), blank());
            if (kind == 1) begin
                k = $urandom_range(0, hdr_q.size() - 1);
                if ($urandom_range(0, 1)) hdr_q[k] = 8'($urandom_range(0, 255));
                else while (hdr_q.size() > k + 1) hdr_q.delete(hdr_q.size() - 1);
            end
        end
        foreach (hdr_q[i]) begin
            b.ch   = hdr_q[i];
            b.lst  = (i == hdr_q.size() - 1);
            b.size = OB'(sz);
            pend_q.insert(pend_q.size(), b);
        end
    endtask

    // ---- sender ----
    always @(posedge i_clk) begin
        t_hdr_beat nb;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            src_gap     <= 0;
        end else if (!in_if.valid || in_if.ready) begin
            if (src_gap != 0) begin
                src_gap     <= src_gap - 1;
                in_if.valid <= 1'b0;
            end else if (pend_q.size() == 0) begin
                in_if.valid <= 1'b0;
            end else if (pend_q.size() > TAIL_BEATS && $urandom_range(0, 11) == 0) begin
                src_gap     <= $urandom_range(0, 9);
                in_if.valid <= 1'b0;
            end else begin
                nb                  = pend_q.pop_front();
                in_if.valid         <= 1'b1;
                in_if.value_byte    <= nb.ch;
                in_if.last_byte     <= nb.lst;
                in_if.resource_size <= nb.size;
            end
        end
    end

    // ---- long output stall, once ----
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && beats_in >= hold_at) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
    end

    // ---- receiver ----
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            snk_gap      <= 0;
        end else if (hold_left != 0) begin
            out_if.ready <= 1'b0;
        end else if (snk_gap != 0) begin
            snk_gap      <= snk_gap - 1;
            out_if.ready <= 1'b0;
        end else if (pend_q.size() > TAIL_BEATS && $urandom_range(0, 7) == 0) begin
            snk_gap      <= $urandom_range(0, 9);
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // ---- monitor: predict on input beats, check output beats ----
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                beats_in <= beats_in + 1;
                scan_char(in_if.value_byte);
                if (in_if.last_byte) begin
                    range_q.insert(range_q.size(), close_header(in_if.resource_size));
                    n_headers++;
                end
            end
            if (out_if.valid && out_if.ready) begin
                if (range_q.size() == 0) begin
                    report("result with nothing pending", {out_if.range_status,
                           out_if.range_first}, 64'd0);
                end else begin
                    want = range_q.pop_front();
                    check_field("range_status", 64'(out_if.range_status), 64'(want.status));
                    check_field("range_first", 64'(out_if.range_first), 64'(want.first));
                    check_field("range_last", 64'(out_if.range_last), 64'(want.last));
                    if (want.status) n_bad++;
                    else n_ok++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        errors              = 0;
        beats_in            = 0;
        n_headers           = 0;
        n_ok                = 0;
        n_bad               = 0;
        cycles              = 0;
        hold_at             = 0;
        i_rst_n             = 1'b0;
        in_if.valid         = 1'b0;
        in_if.value_byte    = '0;
        in_if.last_byte     = 1'b0;
        in_if.resource_size = '0;
        out_if.ready        = 1'b0;
        clear_scan();

        push_text("bytes=0-499", 48'd1000, 1'b1);
        push_text(" \tBYTES=500-\t", 48'd1000, 1'b1);
        push_text("bytes=-200", 48'd1000, 1'b1);
        push_text("ByTeS=-5000", 48'd1000, 1'b1);          // suffix longer than resource
        push_text("bytes=0-", 48'd0, 1'b1);                 // zero size
        push_text("bytes=1000-", 48'd1000, 1'b1);           // first at size
        push_text("bytes=5-3", 48'd1000, 1'b1);             // last below first
        push_text("bytes=-", 48'd1000, 1'b1);
        push_text("bytes=-0", 48'd1000, 1'b1);
        push_text("bytes=0-1,2-3", 48'd1000, 1'b1);         // comma
        push_text("bytes=1-2-3", 48'd1000, 1'b1);           // second dash
        push_text("bytes=1 -2", 48'd1000, 1'b1);            // gap inside spec
        push_text("bytes=1a-2", 48'd1000, 1'b1);            // letter in spec
        push_text("bites=0-1", 48'd1000, 1'b1);             // prefix mismatch
        push_text("byt", 48'd1000, 1'b1);                   // short header
        push_text("bytes=12", 48'd1000, 1'b1);              // no dash
        push_text(" ", 48'd1000, 1'b1);
        add_byte(8'h00, 48'd5, 1'b1);                       // lone NUL character
        push_text("bytes= 7-9 ", 48'd1000, 1'b1);
        push_text("bytes=0-281474976710655", OB'(OFFSET_MAX), 1'b1);
        push_text("bytes=281474976710654-", OB'(OFFSET_MAX), 1'b1);
        push_text("bytes=281474976710656-", OB'(OFFSET_MAX), 1'b1); // overflow
        push_text("bytes=0-99999999999999999999", OB'(OFFSET_MAX), 1'b1);
        push_text("bytes=1", 48'd1000, 1'b0);               // no last mark yet
        push_text("0-20", 48'd1000, 1'b1);
        push_text("bytes=bytes=0-1", 48'd1000, 1'b1);

        hold_at = pend_q.size() + 150;
        while (pend_q.size() < ITEM_BEATS) gen_header();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pend_q.size() != 0 || in_if.valid) @(posedge i_clk);
        while (range_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("tb: %0d header bytes, %0d headers: %0d satisfiable, %0d rejected",
                 beats_in, n_headers, n_ok, n_bad);
        $display("tb: random gaps on both sides plus one %0d-cycle output stall", HOLD_LEN);
        if (errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
